@@ hw/rtl/wsml_pkg.sv @@
// Package for the wheel speed magnitude limiter: widths, codes, stage types
// and helper functions: the square root step, rounding and saturation.
// Depends on nothing; used by wheel_speed_magnitude_limiter_top.
`default_nettype none

package wsml_pkg;

  localparam int L8_W      = 18;
  localparam int MAG_W     = 18;
  localparam int RAD_W     = 36;
  localparam int SQ_STEPS  = RAD_W / 2;
  localparam int SQREM_W   = 20;
  localparam int TGT_W     = 19;
  localparam int DIV_STEPS = 27;
  localparam int SCL_W     = 27;
  localparam int PROD_W    = 46;
  localparam int SPD_W     = 10;
  localparam int FS_W      = 9;
  localparam int THR_W     = 10;

  localparam logic [FS_W-1:0]  FS_RESET    = 9'd500;
  localparam logic [THR_W-1:0] THR_RESET   = 10'd30;
  localparam logic [PROD_W-1:0] SPEED_LIMIT = 46'd500;

  typedef enum logic [2:0] {
    CMD_PASSIVE = 3'd0,
    CMD_SAFE    = 3'd1,
    CMD_FULL    = 3'd2,
    CMD_DRIVE   = 3'd3,
    CMD_STOP    = 3'd4
  } cmd_t;

  localparam logic [2:0] REQ_PASSIVE = 3'd0;
  localparam logic [2:0] REQ_SAFE    = 3'd1;
  localparam logic [2:0] REQ_FULL    = 3'd2;
  localparam logic [2:0] REQ_DRIVE   = 3'd3;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_DOWN = 2'd1,
    ACT_UP   = 2'd2
  } act_t;

  typedef enum logic {
    CFG_FULL_SCALE = 1'b0,
    CFG_STEP_THR   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                    valid;
    logic                    drive;
    cmd_t                    code;
    logic signed [L8_W-1:0]  l8;
    logic signed [L8_W-1:0]  r8;
    logic [THR_W-1:0]        thr;
  } itm_t;

  typedef struct packed {
    logic [RAD_W-1:0]   rad;
    logic [RAD_W-1:0]   radc;
    logic [SQREM_W-1:0] rem;
    logic [SQREM_W-1:0] remc;
    logic [MAG_W-1:0]   root;
    logic [MAG_W-1:0]   rootc;
  } sq_t;

  typedef struct packed {
    logic [SQREM_W-1:0] rem;
    logic [MAG_W-1:0]   root;
  } sqr_t;

  typedef struct packed {
    logic [TGT_W-1:0] tgt;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] rem;
    logic [SCL_W-1:0] q;
    logic             scaled;
    act_t             act;
  } dv_t;

  function automatic sqr_t sq_step(input logic [SQREM_W-1:0] rem,
                                   input logic [MAG_W-1:0] root,
                                   input logic [1:0] two);
    logic [SQREM_W+1:0] sh;
    logic [SQREM_W+1:0] trial;
    sqr_t               res;
    sh    = {rem, two};
    trial = {{(SQREM_W-MAG_W){1'b0}}, root, 2'b01};
    if (sh >= trial) begin
      res.rem  = SQREM_W'(sh - trial);
      res.root = {root[MAG_W-2:0], 1'b1};
    end else begin
      res.rem  = SQREM_W'(sh);
      res.root = {root[MAG_W-2:0], 1'b0};
    end
    return res;
  endfunction

  function automatic logic signed [L8_W-1:0] rnd_shift7(input logic signed [25:0] p);
    logic [25:0] mag;
    logic [25:0] r;
    mag = p[25] ? 26'(-p) : 26'(p);
    r   = (mag + 26'd64) >> 7;
    return p[25] ? L8_W'(-$signed({1'b0, r[L8_W-2:0]})) : L8_W'({1'b0, r[L8_W-2:0]});
  endfunction

  function automatic logic signed [SPD_W-1:0] round_sat(input logic signed [PROD_W-1:0] v,
                                                       input logic [4:0] k);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] r;
    logic [SPD_W-1:0]  m10;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    r   = (mag + (PROD_W'(1) << (k - 5'd1))) >> k;
    m10 = (r > SPEED_LIMIT) ? SPD_W'(SPEED_LIMIT) : r[SPD_W-1:0];
    return v[PROD_W-1] ? $signed(SPD_W'(-m10)) : $signed(m10);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wheel_speed_magnitude_limiter_top.sv @@
// Wheel speed magnitude limiter: a result strobe follows each accepted word.
// One word may be accepted every cycle; busy stays low and the receiver cannot stall.
// The pipeline holds 18 square root stages and 27 divider stages, one bit each.
// Synchronous reset clears the stage valid bits and loads full_scale_speed 500, threshold 30.
// Depends on wsml_pkg.
`default_nettype none

module wheel_speed_magnitude_limiter_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    req_type,
  input  wire logic signed [15:0]            left_stick,
  input  wire logic signed [15:0]            right_stick,
  input  wire logic signed [9:0]             current_left_speed,
  input  wire logic signed [9:0]             current_right_speed,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [9:0]                    cfg_data,
  output logic                               result_valid,
  output logic [2:0]                         command_code,
  output logic signed [9:0]                  left_speed_out,
  output logic signed [9:0]                  right_speed_out,
  output logic [1:0]                         scale_action
);
  import wsml_pkg::*;

  logic [FS_W-1:0]  full_scale_speed;
  logic [THR_W-1:0] step_threshold;

  logic                    v1, drive1;
  cmd_t                    code1, code_in;
  logic [FS_W-1:0]         fs1;
  logic [THR_W-1:0]        thr1;
  logic signed [15:0]      ls1, rs1;
  logic signed [9:0]       cl1, cr1;

  logic                    v2, drive2;
  cmd_t                    code2;
  logic [THR_W-1:0]        thr2;
  logic signed [25:0]      pl2, pr2;
  logic signed [19:0]      clsq2, crsq2;

  itm_t                    it3, it4;
  logic [19:0]             csum3, csum4;
  logic signed [35:0]      lsq4, rsq4;

  itm_t                    sq_itm [SQ_STEPS+1];
  sq_t                     sq     [SQ_STEPS+1];
  sq_t                     sq_d   [SQ_STEPS+1];

  itm_t                    dv_itm [DIV_STEPS+1];
  dv_t                     dv     [DIV_STEPS+1];
  dv_t                     dv_d   [DIV_STEPS+1];
  dv_t                     dv0_d;

  itm_t                    it_m;
  logic                    scaled_m;
  act_t                    act_m;
  logic signed [PROD_W-1:0] prodl_m, prodr_m;

  // A stage word passes on unchanged, but its valid bit is cleared during reset.
  function automatic itm_t flush(input itm_t t, input logic clr);
    itm_t r;
    r = t;
    r.valid = t.valid && !clr;
    return r;
  endfunction

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_speed <= FS_RESET;
      step_threshold   <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FULL_SCALE: full_scale_speed <= cfg_data[FS_W-1:0];
        CFG_STEP_THR:   step_threshold   <= cfg_data;
      endcase
    end
  end

  always_comb begin
    unique case (req_type)
      REQ_PASSIVE: code_in = CMD_PASSIVE;
      REQ_SAFE:    code_in = CMD_SAFE;
      REQ_FULL:    code_in = CMD_FULL;
      REQ_DRIVE:   code_in = CMD_DRIVE;
      default:     code_in = CMD_STOP;
    endcase
  end

  always_ff @(posedge clk) begin
    v1     <= start && !busy && !rst;
    code1  <= code_in;
    drive1 <= (req_type == REQ_DRIVE);
    fs1    <= full_scale_speed;
    thr1   <= step_threshold;
    ls1    <= left_stick;
    rs1    <= right_stick;
    cl1    <= current_left_speed;
    cr1    <= current_right_speed;

    v2     <= v1 && !rst;
    code2  <= code1;
    drive2 <= drive1;
    thr2   <= thr1;
    pl2    <= $signed({1'b0, fs1}) * ls1;
    pr2    <= $signed({1'b0, fs1}) * rs1;
    clsq2  <= cl1 * cl1;
    crsq2  <= cr1 * cr1;

    it3.valid <= v2 && !rst;
    it3.drive <= drive2;
    it3.code  <= code2;
    it3.thr   <= thr2;
    it3.l8    <= rnd_shift7(pl2);
    it3.r8    <= rnd_shift7(pr2);
    csum3     <= 20'(clsq2) + 20'(crsq2);

    it4   <= flush(it3, rst);
    lsq4  <= it3.l8 * it3.l8;
    rsq4  <= it3.r8 * it3.r8;
    csum4 <= csum3;

    sq_itm[0]      <= flush(it4, rst);
    sq[0].rad      <= RAD_W'(lsq4) + RAD_W'(rsq4) + RAD_W'(65536);
    sq[0].radc     <= {csum4, 16'h0000} + RAD_W'(65536);
    sq[0].rem      <= '0;
    sq[0].remc     <= '0;
    sq[0].root     <= '0;
    sq[0].rootc    <= '0;

    for (int j = 0; j < SQ_STEPS; j++) begin
      sq_itm[j+1] <= flush(sq_itm[j], rst);
      sq[j+1]     <= sq_d[j+1];
    end

    dv_itm[0] <= flush(sq_itm[SQ_STEPS], rst);
    dv[0]     <= dv0_d;
    for (int j = 0; j < DIV_STEPS; j++) begin
      dv_itm[j+1] <= flush(dv_itm[j], rst);
      dv[j+1]     <= dv_d[j+1];
    end

    it_m     <= flush(dv_itm[DIV_STEPS], rst);
    scaled_m <= dv[DIV_STEPS].scaled;
    act_m    <= dv[DIV_STEPS].act;
    prodl_m  <= dv_itm[DIV_STEPS].l8 * $signed({1'b0, dv[DIV_STEPS].q});
    prodr_m  <= dv_itm[DIV_STEPS].r8 * $signed({1'b0, dv[DIV_STEPS].q});

    result_valid <= it_m.valid && !rst;
    command_code <= it_m.code;
    if (!it_m.drive) begin
      left_speed_out  <= '0;
      right_speed_out <= '0;
      scale_action    <= ACT_NONE;
    end else if (scaled_m) begin
      left_speed_out  <= round_sat(prodl_m, 5'd24);
      right_speed_out <= round_sat(prodr_m, 5'd24);
      scale_action    <= act_m;
    end else begin
      left_speed_out  <= round_sat(PROD_W'(it_m.l8), 5'd8);
      right_speed_out <= round_sat(PROD_W'(it_m.r8), 5'd8);
      scale_action    <= ACT_NONE;
    end
  end

  always_comb begin
    sqr_t a;
    sqr_t b;
    sq_d[0] = sq[0];
    for (int j = 0; j < SQ_STEPS; j++) begin
      a = sq_step(sq[j].rem,  sq[j].root,  sq[j].rad[RAD_W-1-2*j -: 2]);
      b = sq_step(sq[j].remc, sq[j].rootc, sq[j].radc[RAD_W-1-2*j -: 2]);
      sq_d[j+1]       = sq[j];
      sq_d[j+1].rem   = a.rem;
      sq_d[j+1].root  = a.root;
      sq_d[j+1].remc  = b.rem;
      sq_d[j+1].rootc = b.root;
    end
  end

  always_comb begin
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] magc;
    logic [MAG_W-1:0] t8;
    logic             up;
    logic             down;
    mag  = sq[SQ_STEPS].root;
    magc = sq[SQ_STEPS].rootc;
    t8   = {sq_itm[SQ_STEPS].thr, 8'h00};
    down = 20'(mag) > 20'(magc) + 20'(t8);
    up   = 20'(magc) > 20'(mag) + 20'(t8);
    dv0_d.mag    = mag;
    dv0_d.q      = '0;
    dv0_d.scaled = down || up;
    if (down) begin
      dv0_d.tgt = TGT_W'(magc) + TGT_W'(t8);
      dv0_d.act = ACT_DOWN;
    end else if (up) begin
      dv0_d.tgt = TGT_W'(magc) - TGT_W'(t8);
      dv0_d.act = ACT_UP;
    end else begin
      dv0_d.tgt = '0;
      dv0_d.act = ACT_NONE;
    end
    dv0_d.rem = MAG_W'(dv0_d.tgt[TGT_W-1:11]);
  end

  always_comb begin
    logic [DIV_STEPS-1:0] num;
    logic [MAG_W:0]       sh;
    dv_d[0] = dv[0];
    for (int j = 0; j < DIV_STEPS; j++) begin
      num     = {dv[j].tgt[10:0], 16'h0000};
      sh      = {dv[j].rem, num[DIV_STEPS-1-j]};
      dv_d[j+1] = dv[j];
      if (sh >= {1'b0, dv[j].mag}) begin
        dv_d[j+1].rem = MAG_W'(sh - {1'b0, dv[j].mag});
        dv_d[j+1].q   = {dv[j].q[SCL_W-2:0], 1'b1};
      end else begin
        dv_d[j+1].rem = MAG_W'(sh);
        dv_d[j+1].q   = {dv[j].q[SCL_W-2:0], 1'b0};
      end
    end
  end

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_mode_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (command_code != CMD_DRIVE) |->
      (left_speed_out == '0) && (right_speed_out == '0) && (scale_action == ACT_NONE))
    else $error("mode word carries speeds");

  a_action_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (scale_action != 2'd3))
    else $error("bad scale action");

  a_sqrt_to_div: assert property (@(posedge clk) disable iff (rst)
    sq_itm[SQ_STEPS].valid |=> dv_itm[0].valid)
    else $error("word lost between root and divider");

endmodule

`default_nettype wire
